@@ rtl/itda_pkg.sv @@
// shared types and constants for the 64-bit integer to decimal text converter
`timescale 1ns / 1ps

package itda_pkg;

  localparam int InWidth    = 64;
  localparam int NumDigits  = 19;
  localparam int DigitCntW  = $clog2(NumDigits + 1);
  localparam int BitCntW    = $clog2(InWidth);
  localparam int CharWidth  = 7;

  localparam logic [CharWidth-1:0] CharMinus = 7'd45;
  localparam logic [CharWidth-1:0] CharZero  = 7'd48;
  localparam logic [CharWidth-1:0] CharNine  = 7'd57;

  localparam logic [3:0] DigitAdjustMin = 4'd5;
  localparam logic [3:0] DigitAdjustAdd = 4'd3;
  localparam logic [3:0] DigitZero      = 4'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift_bit;
    logic shift_digit;
  } cell_ctl_t;

endpackage

@@ rtl/itda_if.sv @@
// valid/ready channel interfaces for the integer input and the character output
`timescale 1ns / 1ps

interface itda_value_if;
  logic        valid;
  logic        ready;
  logic signed [itda_pkg::InWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_char_if;
  logic        valid;
  logic        ready;
  logic [itda_pkg::CharWidth-1:0] character;
  logic        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/itda_bcd_cell.sv @@
// one decimal digit cell of the shift-and-add-3 chain
`timescale 1ns / 1ps

module itda_bcd_cell (
  input  logic                clk,
  input  itda_pkg::cell_ctl_t ctl,
  input  logic                bit_in,
  input  logic [3:0]          digit_in,
  output logic                carry,
  output logic [3:0]          digit
);

  logic [3:0] adj;

  // add 3 before the shift when the digit would overflow past nine
  assign adj   = (digit >= itda_pkg::DigitAdjustMin) ?
                 (digit + itda_pkg::DigitAdjustAdd) : digit;
  assign carry = adj[3];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= itda_pkg::DigitZero;
    end else if (ctl.shift_bit) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctl.shift_digit) begin
      digit <= digit_in;
    end
  end

endmodule

@@ rtl/int64_to_decimal_ascii.sv @@
// steps: accept in idle, bit-serial conversion of the magnitude, then a walk dropping leading
// zeros (one digit shift per leading zero), then one character per cycle (up to 20) while ready,
// a minus sign first for a negative value; throughput is set by the bit-serial binary to bcd
// chain, the leading-zero walk and output stalls
// input is taken only when the previous text has fully left the block
// reset (rst, synchronous, active high) returns the control to idle; no result pending
`timescale 1ns / 1ps

module int64_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  itda_value_if.sink  num,
  itda_char_if.source text
);

  localparam int ND = itda_pkg::NumDigits;
  localparam int NW = itda_pkg::InWidth;
  localparam int CW = itda_pkg::DigitCntW;
  localparam int BW = itda_pkg::BitCntW;

  itda_pkg::state_t state, state_next;

  // magnitude shift register, msb feeds the lowest digit cell
  logic [NW-1:0] mag;
  logic          neg;
  logic [BW-1:0] bit_cnt;
  // digits still to be shown, counted from the top cell downward
  logic [CW-1:0] remaining;

  itda_pkg::cell_ctl_t ctl;

  logic [3:0] digit [ND];
  logic       carry [ND];
  logic [3:0] top_digit;
  logic       out_done;
  logic       top_is_lead_zero;

  // row of digit cells: cell 0 is least significant
  for (genvar i = 0; i < ND; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] digit_in;
    if (i == 0) begin : g_first
      assign bit_in   = mag[NW-1];
      assign digit_in = itda_pkg::DigitZero;
    end else begin : g_rest
      assign bit_in   = carry[i-1];
      assign digit_in = digit[i-1];
    end
    itda_bcd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .bit_in   (bit_in),
      .digit_in (digit_in),
      .carry    (carry[i]),
      .digit    (digit[i])
    );
  end

  assign top_digit        = digit[ND-1];
  assign out_done         = (remaining == CW'(1));
  assign top_is_lead_zero = (top_digit == itda_pkg::DigitZero) && !out_done;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      itda_pkg::ST_IDLE: begin
        if (num.valid) state_next = itda_pkg::ST_CONVERT;
      end
      itda_pkg::ST_CONVERT: begin
        if (bit_cnt == BW'(NW - 1)) state_next = itda_pkg::ST_SKIP;
      end
      itda_pkg::ST_SKIP: begin
        if (!top_is_lead_zero) begin
          state_next = neg ? itda_pkg::ST_SIGN : itda_pkg::ST_EMIT;
        end
      end
      itda_pkg::ST_SIGN: begin
        if (text.ready) state_next = itda_pkg::ST_EMIT;
      end
      itda_pkg::ST_EMIT: begin
        if (text.ready && out_done) state_next = itda_pkg::ST_IDLE;
      end
      default: state_next = itda_pkg::ST_IDLE;
    endcase
  end

  // outputs and cell controls
  always_comb begin
    ctl            = '0;
    num.ready      = 1'b0;
    text.valid     = 1'b0;
    text.character = itda_pkg::CharZero + {3'b000, top_digit};
    text.last      = 1'b0;
    case (state)
      itda_pkg::ST_IDLE: begin
        num.ready = 1'b1;
        ctl.clear = num.valid;
      end
      itda_pkg::ST_CONVERT: begin
        ctl.shift_bit = 1'b1;
      end
      itda_pkg::ST_SKIP: begin
        ctl.shift_digit = top_is_lead_zero;
      end
      itda_pkg::ST_SIGN: begin
        text.valid     = 1'b1;
        text.character = itda_pkg::CharMinus;
      end
      itda_pkg::ST_EMIT: begin
        text.valid      = 1'b1;
        text.last       = out_done;
        ctl.shift_digit = text.ready && !out_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers; counters are only read in states they were set for
  always_ff @(posedge clk) begin
    if (num.valid && num.ready) begin
      neg       <= num.value[NW-1];
      // unsigned negate also covers the most negative value
      mag       <= num.value[NW-1] ? (~num.value + NW'(1)) : num.value;
      bit_cnt   <= '0;
      remaining <= CW'(ND);
    end else begin
      if (ctl.shift_bit) begin
        mag     <= {mag[NW-2:0], 1'b0};
        bit_cnt <= bit_cnt + BW'(1);
      end
      if (ctl.shift_digit) begin
        remaining <= remaining - CW'(1);
      end
    end
  end

endmodule

@@ rtl/itda_checker.sv @@
// port-level checks for the integer to decimal text converter, bound to the top level
`timescale 1ns / 1ps

module itda_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           num_ready,
  input logic                           text_valid,
  input logic                           text_ready,
  input logic [itda_pkg::CharWidth-1:0] text_character,
  input logic                           text_last
);

  // a new value is never taken while text is still going out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(num_ready && text_valid))
    else $error("input accepted while output text pending");

  // a stalled character holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=>
      text_valid && $stable(text_character) && $stable(text_last))
    else $error("output changed while stalled");

  // only a minus sign or a decimal digit comes out
  a_charset: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> (text_character == itda_pkg::CharMinus) ||
                   (text_character >= itda_pkg::CharZero &&
                    text_character <= itda_pkg::CharNine))
    else $error("character outside sign and digit set");

  // the sign never ends a run
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    text_valid && (text_character == itda_pkg::CharMinus) |-> !text_last)
    else $error("minus sign flagged as last");

  // after the last transaction of a run the block goes back to taking input
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_ready && text_last |=> num_ready && !text_valid)
    else $error("block not idle after final character");

endmodule

bind int64_to_decimal_ascii itda_checker u_itda_checker (
  .clk            (clk),
  .rst            (rst),
  .num_ready      (num.ready),
  .text_valid     (text.valid),
  .text_ready     (text.ready),
  .text_character (text.character),
  .text_last      (text.last)
);

@@ tb/testbench.sv @@
// self-checking testbench for the 64-bit signed integer to decimal text converter
`timescale 1ns / 1ps

module testbench;

  // one character of decimal text as it leaves the block
  typedef struct packed {
    logic [itda_pkg::CharWidth-1:0] character;
    logic                           last;
  } text_char_t;

  localparam int NumRows     = 22;
  localparam int NumPhases   = 4;
  localparam int RandomItems = 348;
  localparam int DrainCycles = 110;   // load + convert + leading-zero skip + margin
  localparam int TimeLimitNs = 2_000_000;

  // per phase: percent of cycles the sender idles and the receiver stalls
  localparam int PhaseIdle  [NumPhases] = '{0, 52, 0, 20};
  localparam int PhaseStall [NumPhases] = '{0, 0, 52, 20};

  logic clk;
  logic rst;

  itda_value_if num_ch ();
  itda_char_if  text_ch ();

  // directed rows: value to convert and its text when it is plain to see
  // an empty string means the predictor works out the text
  logic [itda_pkg::InWidth-1:0] row_value [NumRows] = '{
    64'd0,
    64'd1,
    -64'sd1,
    64'd9,
    64'd10,
    -64'sd10,
    64'd99,
    64'd100,
    64'd12345,
    -64'sd987654321,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001,
    64'd999999999999999999,
    64'd1000000000000000000,
    64'd4294967295,
    64'd4294967296,
    -64'sd4294967296,
    64'd5,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'd8000000000000000000
  };

  string row_text [NumRows] = '{
    "0",
    "1",
    "-1",
    "9",
    "10",
    "-10",
    "",
    "",
    "",
    "",
    "9223372036854775807",
    "-9223372036854775808",
    "-9223372036854775807",
    "",
    "1000000000000000000",
    "",
    "",
    "",
    "5",
    "",
    "",
    ""
  };

  text_char_t exp_q [$];
  text_char_t exp_c;
  int         errors        = 0;
  int         sent          = 0;
  int         chars_checked = 0;
  int         idle_pct      = 0;
  int         stall_pct     = 0;

  int64_to_decimal_ascii uut (
    .clk  (clk),
    .rst  (rst),
    .num  (num_ch),
    .text (text_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // decimal text of a value, magnitude taken as unsigned
  function automatic string predict_text(input logic [itda_pkg::InWidth-1:0] raw);
    logic [itda_pkg::InWidth-1:0] mag;
    string                        s;
    mag = raw[itda_pkg::InWidth-1] ? (~raw + 1'b1) : raw;
    s   = $sformatf("%0d", mag);
    if (raw[itda_pkg::InWidth-1]) s = {"-", s};
    return s;
  endfunction

  // queue the characters of one value's text, last flagged on the final one
  function automatic void push_text(input string s);
    text_char_t c;
    byte        b;
    for (int k = 0; k < s.len(); k++) begin
      b           = s[k];
      c.character = b[itda_pkg::CharWidth-1:0];
      c.last      = (k == s.len() - 1);
      exp_q.push_back(c);
    end
  endfunction

  function automatic logic [itda_pkg::InWidth-1:0] random_value();
    logic [itda_pkg::InWidth-1:0] v;
    logic [itda_pkg::InWidth-1:0] p;
    p = 64'd1;
    case ($urandom_range(0, 3))
      0: begin
        v = {$urandom(), $urandom()};
      end
      1: begin
        v = 64'($urandom_range(0, 2000));
        if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
      end
      2: begin
        // around a power of ten
        repeat ($urandom_range(0, 18)) p = p * 64'd10;
        v = p + 64'($urandom_range(0, 2)) - 64'd1;
        if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
      end
      default: begin
        // near the most negative or the most positive value
        if ($urandom_range(0, 1) == 1) v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
        else v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      end
    endcase
    return v;
  endfunction

  // present one value and return at the edge that accepts it
  task automatic send_value(input logic [itda_pkg::InWidth-1:0] v, input int idle);
    if (int'($urandom_range(0, 99)) < idle) begin
      num_ch.valid <= 1'b0;
      @(posedge clk);
      while (int'($urandom_range(0, 99)) < idle) @(posedge clk);
    end
    num_ch.valid <= 1'b1;
    num_ch.value <= v;
    do @(posedge clk); while (!num_ch.ready);
    sent++;
  endtask

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      text_ch.ready <= 1'b0;
    end else begin
      text_ch.ready <= (int'($urandom_range(0, 99)) >= stall_pct);
    end
  end

  // output monitor and scoreboard
  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready) begin
      if (exp_q.size() == 0) begin
        errors++;
        $display("%0t: expected no character, actual char %0d last %0b",
                 $time, text_ch.character, text_ch.last);
      end else begin
        exp_c = exp_q.pop_front();
        chars_checked++;
        if (text_ch.character !== exp_c.character || text_ch.last !== exp_c.last) begin
          errors++;
          $display("%0t: expected char %0d last %0b, actual char %0d last %0b",
                   $time, exp_c.character, exp_c.last, text_ch.character, text_ch.last);
        end
      end
    end
  end

  initial begin : main
    logic [itda_pkg::InWidth-1:0] v;
    rst          <= 1'b1;
    num_ch.valid <= 1'b0;
    num_ch.value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NumPhases; p++) begin
      idle_pct  = PhaseIdle[p];
      stall_pct = PhaseStall[p];
      if (p == 0) begin
        for (int r = 0; r < NumRows; r++) begin
          send_value(row_value[r], idle_pct);
          if (row_text[r].len() != 0) push_text(row_text[r]);
          else push_text(predict_text(row_value[r]));
        end
      end
      for (int n = 0; n < RandomItems / NumPhases; n++) begin
        v = random_value();
        send_value(v, idle_pct);
        push_text(predict_text(v));
      end
    end
    num_ch.valid <= 1'b0;

    while (exp_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("converted %0d values (%0d table rows, rest random), %0d characters checked",
             sent, NumRows, chars_checked);
    $display("handshake phases: free running, sender gaps, receiver stalls, both mixed");
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #(TimeLimitNs);
    $display("%0t: run did not finish, %0d characters still expected", $time, exp_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ int64_to_decimal_ascii.f @@
rtl/itda_pkg.sv
rtl/itda_if.sv
rtl/itda_bcd_cell.sv
rtl/int64_to_decimal_ascii.sv
rtl/itda_checker.sv
tb/testbench.sv
